@@ src/lmf_pkg.sv @@
`default_nettype none

package lmf_pkg;

    localparam logic [3:0] MODE_NONE       = 4'd0;
    localparam logic [3:0] MODE_DISC       = 4'd1;
    localparam logic [3:0] MODE_DISC_OPEN  = 4'd5;
    localparam logic [3:0] MODE_LOWER_ALPH = 4'd7;
    localparam logic [3:0] MODE_UPPER_ALPH = 4'd8;
    localparam logic [3:0] MODE_LOWER_ROM  = 4'd9;
    localparam logic [3:0] MODE_UPPER_ROM  = 4'd10;

    localparam logic [31:0] ROMAN_LIMIT = 32'd4000;

    // reciprocals for divide by constant, low estimate corrected by one compare
    localparam logic [31:0] RECIP_DEC   = 32'd3435973836;
    localparam logic [31:0] RECIP_ALPHA = 32'd2643056797;
    localparam logic [5:0]  BASE_DEC    = 6'd10;
    localparam logic [5:0]  BASE_ALPHA  = 6'd26;

    localparam int BUF_DEPTH = 17;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);

    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CASE_GAP  = 8'h20;
    localparam logic [3:0] ROMAN_LAST = 4'd12;

    typedef enum logic [1:0] {
        KIND_GLYPH = 2'd0,
        KIND_DEC   = 2'd1,
        KIND_ALPHA = 2'd2,
        KIND_ROMAN = 2'd3
    } kind_t;

    typedef struct packed {
        logic [3:0]         mode;
        logic signed [31:0] item_number;
    } in_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } out_t;

    typedef struct packed {
        kind_t       kind;
        logic        upper;
        logic        neg;
        logic [2:0]  glyph_sel;
        logic [31:0] value;
    } cmd_t;

    function automatic logic [7:0] glyph_byte(input logic [2:0] sel, input logic [1:0] idx);
        logic [7:0] b;
        b = 8'he2;
        case (idx)
            2'd0: b = 8'he2;
            2'd1: begin
                case (sel)
                    3'd0: b = 8'h80;
                    3'd1: b = 8'h97;
                    default: b = 8'h96;
                endcase
            end
            2'd2: begin
                case (sel)
                    3'd0: b = 8'ha2;
                    3'd1: b = 8'ha6;
                    3'd2: b = 8'haa;
                    3'd3: b = 8'hb8;
                    default: b = 8'hbe;
                endcase
            end
            default: b = CH_SPACE;
        endcase
        return b;
    endfunction

    function automatic logic [11:0] rn_value(input logic [3:0] i);
        logic [11:0] v;
        case (i)
            4'd0:  v = 12'd1000;
            4'd1:  v = 12'd900;
            4'd2:  v = 12'd500;
            4'd3:  v = 12'd400;
            4'd4:  v = 12'd100;
            4'd5:  v = 12'd90;
            4'd6:  v = 12'd50;
            4'd7:  v = 12'd40;
            4'd8:  v = 12'd10;
            4'd9:  v = 12'd9;
            4'd10: v = 12'd5;
            4'd11: v = 12'd4;
            default: v = 12'd1;
        endcase
        return v;
    endfunction

    // first letter of the numeral, upper case
    function automatic logic [7:0] rn_first(input logic [3:0] i);
        logic [7:0] c;
        case (i)
            4'd0:  c = "M";
            4'd1:  c = "C";
            4'd2:  c = "D";
            4'd3:  c = "C";
            4'd4:  c = "C";
            4'd5:  c = "X";
            4'd6:  c = "L";
            4'd7:  c = "X";
            4'd8:  c = "X";
            4'd9:  c = "I";
            4'd10: c = "V";
            4'd11: c = "I";
            default: c = "I";
        endcase
        return c;
    endfunction

    function automatic logic [7:0] rn_second(input logic [3:0] i);
        logic [7:0] c;
        case (i)
            4'd1:  c = "M";
            4'd3:  c = "D";
            4'd5:  c = "C";
            4'd7:  c = "L";
            4'd9:  c = "X";
            4'd11: c = "V";
            default: c = "I";
        endcase
        return c;
    endfunction

    function automatic logic rn_two(input logic [3:0] i);
        return i[0];
    endfunction

endpackage

`default_nettype wire

@@ src/lmf_front.sv @@
`default_nettype none

module lmf_front (
    input  wire logic         s_valid,
    input  wire lmf_pkg::in_t s_data,
    input  wire logic         q_full,
    output logic              s_ready,
    output logic              push,
    output lmf_pkg::cmd_t     cmd
);

    logic [31:0] raw;
    logic        neg;
    logic        pos;
    logic [3:0]  m;

    assign s_ready = !q_full;

    always_comb begin
        m   = s_data.mode;
        raw = s_data.item_number;
        neg = raw[31];
        pos = !neg && (raw != 32'd0);

        cmd.upper     = (m == lmf_pkg::MODE_UPPER_ALPH) || (m == lmf_pkg::MODE_UPPER_ROM);
        cmd.neg       = 1'b0;
        cmd.glyph_sel = 3'(m - lmf_pkg::MODE_DISC);
        cmd.value     = raw;
        if (m >= lmf_pkg::MODE_DISC && m <= lmf_pkg::MODE_DISC_OPEN) begin
            cmd.kind = lmf_pkg::KIND_GLYPH;
        end else if ((m == lmf_pkg::MODE_LOWER_ALPH || m == lmf_pkg::MODE_UPPER_ALPH) && pos) begin
            cmd.kind = lmf_pkg::KIND_ALPHA;
        end else if ((m == lmf_pkg::MODE_LOWER_ROM || m == lmf_pkg::MODE_UPPER_ROM) && pos &&
                     raw < lmf_pkg::ROMAN_LIMIT) begin
            cmd.kind = lmf_pkg::KIND_ROMAN;
        end else begin
            cmd.kind  = lmf_pkg::KIND_DEC;
            cmd.neg   = neg;
            cmd.value = neg ? (32'd0 - raw) : raw;
        end
    end

    // style none is taken and dropped
    assign push = s_valid && s_ready && (m != lmf_pkg::MODE_NONE);

endmodule

`default_nettype wire

@@ src/lmf_queue.sv @@
`default_nettype none

module lmf_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire lmf_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output logic               full,
    output logic               not_empty,
    output lmf_pkg::cmd_t      head
);

    lmf_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ src/lmf_back.sv @@
`default_nettype none

module lmf_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_not_empty,
    input  wire lmf_pkg::cmd_t q_head,
    output logic               q_pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output lmf_pkg::out_t      m_data
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MUL   = 8'b0000_0010,
        ST_FIX   = 8'b0000_0100,
        ST_ROMAN = 8'b0000_1000,
        ST_SIGN  = 8'b0001_0000,
        ST_BODY  = 8'b0010_0000,
        ST_DOT   = 8'b0100_0000,
        ST_SPACE = 8'b1000_0000
    } state_t;

    localparam int AW = lmf_pkg::BUF_AW;

    state_t             state_reg, state_next;
    lmf_pkg::kind_t     kind_reg, kind_next;
    logic               upper_reg, upper_next;
    logic               neg_reg, neg_next;
    logic [2:0]         sel_reg, sel_next;
    logic [31:0]        x_reg, x_next;
    logic [63:0]        prod_reg;
    logic [AW-1:0]      cnt_reg, cnt_next;
    logic [AW-1:0]      oidx_reg, oidx_next;
    logic [3:0]         rn_idx_reg, rn_idx_next;
    logic               rn_sec_reg, rn_sec_next;
    logic [7:0]         buf_reg [lmf_pkg::BUF_DEPTH];

    logic               out_valid_reg, out_valid_next;
    lmf_pkg::out_t      out_data_reg, out_data_next;

    logic               wr_en;
    logic [7:0]         wr_char;
    logic               slot_free;
    logic               is_dec;
    logic [31:0]        q_est, qd, q_fix;
    logic [31:0]        rem32;
    logic [5:0]         base, r_fix;
    logic [31:0]        rv;
    logic [7:0]         rn_char;
    logic [AW-1:0]      rd_idx;
    logic [7:0]         body_char;

    assign slot_free = !out_valid_reg || m_ready;
    assign is_dec    = (kind_reg == lmf_pkg::KIND_DEC);

    always_ff @(posedge aclk) begin
        prod_reg <= x_reg * (is_dec ? lmf_pkg::RECIP_DEC : lmf_pkg::RECIP_ALPHA);
    end

    always_comb begin
        base  = is_dec ? lmf_pkg::BASE_DEC : lmf_pkg::BASE_ALPHA;
        q_est = is_dec ? 32'(prod_reg[63:35]) : 32'(prod_reg[63:36]);
        qd    = q_est * 32'(base);
        rem32 = x_reg - qd;
        if (rem32[5:0] >= base) begin
            q_fix = q_est + 32'd1;
            r_fix = rem32[5:0] - base;
        end else begin
            q_fix = q_est;
            r_fix = rem32[5:0];
        end

        rv      = 32'(lmf_pkg::rn_value(rn_idx_reg));
        rn_char = rn_sec_reg ? lmf_pkg::rn_second(rn_idx_reg) : lmf_pkg::rn_first(rn_idx_reg);
        if (!upper_reg) begin
            rn_char = rn_char + lmf_pkg::CASE_GAP;
        end

        rd_idx = (kind_reg == lmf_pkg::KIND_ROMAN) ? oidx_reg : (cnt_reg - oidx_reg - AW'(1));
        if (kind_reg == lmf_pkg::KIND_GLYPH) begin
            body_char = lmf_pkg::glyph_byte(sel_reg, oidx_reg[1:0]);
        end else begin
            body_char = buf_reg[rd_idx];
        end
    end

    always_comb begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        upper_next     = upper_reg;
        neg_next       = neg_reg;
        sel_next       = sel_reg;
        x_next         = x_reg;
        cnt_next       = cnt_reg;
        oidx_next      = oidx_reg;
        rn_idx_next    = rn_idx_reg;
        rn_sec_next    = rn_sec_reg;
        q_pop          = 1'b0;
        wr_en          = 1'b0;
        wr_char        = rn_char;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (q_not_empty) begin
                    q_pop       = 1'b1;
                    kind_next   = q_head.kind;
                    upper_next  = q_head.upper;
                    neg_next    = q_head.neg;
                    sel_next    = q_head.glyph_sel;
                    cnt_next    = '0;
                    oidx_next   = '0;
                    rn_idx_next = '0;
                    rn_sec_next = 1'b0;
                    case (q_head.kind)
                        lmf_pkg::KIND_GLYPH: begin
                            cnt_next   = AW'(3);
                            state_next = ST_BODY;
                        end
                        lmf_pkg::KIND_ALPHA: begin
                            x_next     = q_head.value - 32'd1;
                            state_next = ST_MUL;
                        end
                        lmf_pkg::KIND_ROMAN: begin
                            x_next     = q_head.value;
                            state_next = ST_ROMAN;
                        end
                        default: begin
                            x_next     = q_head.value;
                            state_next = ST_MUL;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                state_next = ST_FIX;
            end
            ST_FIX: begin
                wr_en    = 1'b1;
                wr_char  = is_dec ? (lmf_pkg::CH_ZERO + 8'(r_fix))
                                  : ((upper_reg ? lmf_pkg::CH_UPPER_A : lmf_pkg::CH_LOWER_A)
                                     + 8'(r_fix));
                cnt_next = cnt_reg + AW'(1);
                if (q_fix != 32'd0) begin
                    x_next     = is_dec ? q_fix : (q_fix - 32'd1);
                    state_next = ST_MUL;
                end else begin
                    state_next = neg_reg ? ST_SIGN : ST_BODY;
                end
            end
            ST_ROMAN: begin
                if (x_reg == 32'd0) begin
                    state_next = ST_BODY;
                end else if (x_reg >= rv) begin
                    wr_en    = 1'b1;
                    cnt_next = cnt_reg + AW'(1);
                    if (lmf_pkg::rn_two(rn_idx_reg) && !rn_sec_reg) begin
                        rn_sec_next = 1'b1;
                    end else begin
                        rn_sec_next = 1'b0;
                        x_next      = x_reg - rv;
                    end
                end else if (rn_idx_reg != lmf_pkg::ROMAN_LAST) begin
                    rn_idx_next = rn_idx_reg + 4'd1;
                end
            end
            ST_SIGN: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{text_byte: lmf_pkg::CH_MINUS, last_byte: 1'b0};
                    state_next     = ST_BODY;
                end
            end
            ST_BODY: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{text_byte: body_char, last_byte: 1'b0};
                    oidx_next      = oidx_reg + AW'(1);
                    if (oidx_reg == cnt_reg - AW'(1)) begin
                        state_next = (kind_reg == lmf_pkg::KIND_GLYPH) ? ST_SPACE : ST_DOT;
                    end
                end
            end
            ST_DOT: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{text_byte: lmf_pkg::CH_DOT, last_byte: 1'b0};
                    state_next     = ST_SPACE;
                end
            end
            ST_SPACE: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{text_byte: lmf_pkg::CH_SPACE, last_byte: 1'b1};
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            buf_reg[cnt_reg] <= wr_char;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        upper_reg    <= upper_next;
        neg_reg      <= neg_next;
        sel_reg      <= sel_next;
        x_reg        <= x_next;
        cnt_reg      <= cnt_next;
        oidx_reg     <= oidx_next;
        rn_idx_reg   <= rn_idx_next;
        rn_sec_reg   <= rn_sec_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire

@@ src/list_marker_formatter_top.sv @@
`default_nettype none

// list marker formatter: takes a list style and a signed 32-bit item number and returns the
// marker text one byte per transaction, last_byte set on the final byte; style none returns
// nothing. A front stage classifies each transaction into a two-entry queue, so up to two
// markers are taken while the back end still spells an earlier one. The back end spells one
// marker at a time, after taking it from the queue in its idle state: each decimal or letter
// digit is a reciprocal multiply into a register, then remainder and correction; a Roman
// numeral writes one letter per step, steps on past skipped table entries and stops when
// the value runs out; the output bytes then go out one at a time, stalling while the receiver
// is not ready. The divide-by-constant unit is shared by decimal and letter digits, and there
// is a single output register.
module list_marker_formatter_top (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire lmf_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output lmf_pkg::out_t      m_data
);

    logic          q_full;
    logic          q_not_empty;
    logic          q_push;
    logic          q_pop;
    lmf_pkg::cmd_t push_cmd;
    lmf_pkg::cmd_t q_head;

    lmf_front u_front (
        .s_valid (s_valid),
        .s_data  (s_data),
        .q_full  (q_full),
        .s_ready (s_ready),
        .push    (q_push),
        .cmd     (push_cmd)
    );

    lmf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    lmf_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

`default_nettype wire

@@ test/list_marker_formatter_top_tb.sv @@
module list_marker_formatter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // style codes the package does not name
    localparam logic [3:0] MODE_CIRCLE      = 4'd2;
    localparam logic [3:0] MODE_SQUARE      = 4'd3;
    localparam logic [3:0] MODE_DISC_CLOSED = 4'd4;
    localparam logic [3:0] MODE_DECIMAL     = 4'd6;
    localparam logic [3:0] MODE_UNUSED_LO   = 4'd11;
    localparam logic [3:0] MODE_UNUSED_HI   = 4'd15;

    localparam logic [7:0] TXT_ZERO  = 8'h30;
    localparam logic [7:0] TXT_MINUS = 8'h2d;
    localparam logic [7:0] TXT_DOT   = 8'h2e;
    localparam logic [7:0] TXT_SPACE = 8'h20;
    localparam logic [7:0] TXT_LOW_A = 8'h61;
    localparam logic [7:0] TXT_UP_A  = 8'h41;
    localparam int         MARKER_MAX = 17;
    localparam int         ROMAN_CEIL = 4000;

    localparam int RANDOM_ITEMS = 420;
    localparam int HOLD_AFTER   = 60;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 200000;

    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_MOSTLY,
        SINK_EVERY_THIRD
    } sink_pattern_t;

    class marker_scoreboard;
        lmf_pkg::out_t pending[$];
        int   errors;
        int   markers;
        int   bytes_seen;
        int   style_count[16];

        task report_mismatch(string what);
            $display("ERROR @%0t: %s", $time, what);
            errors++;
        endtask

        function void note_marker(lmf_pkg::in_t item);
            logic [7:0]  text[$];
            logic [7:0]  glyph_mid[5];
            logic [7:0]  glyph_end[5];
            int          step_value[13];
            string       step_text[13];
            logic [31:0] raw;
            logic [31:0] v;
            logic [7:0]  letter_base;
            logic [7:0]  c;
            logic        upper;
            logic        positive;
            glyph_mid = '{8'h80, 8'h97, 8'h96, 8'h96, 8'h96};
            glyph_end = '{8'ha2, 8'ha6, 8'haa, 8'hb8, 8'hbe};
            step_value = '{1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1};
            step_text = '{"M", "CM", "D", "CD", "C", "XC", "L", "XL", "X", "IX", "V", "IV", "I"};
            raw = item.item_number;
            positive = !raw[31] && raw != 32'd0;
            upper = item.mode == lmf_pkg::MODE_UPPER_ALPH
                    || item.mode == lmf_pkg::MODE_UPPER_ROM;
            markers++;
            style_count[item.mode]++;
            if (item.mode == lmf_pkg::MODE_NONE)
                return;
            if (item.mode >= lmf_pkg::MODE_DISC && item.mode <= lmf_pkg::MODE_DISC_OPEN) begin
                text.push_back(8'he2);
                text.push_back(glyph_mid[item.mode - lmf_pkg::MODE_DISC]);
                text.push_back(glyph_end[item.mode - lmf_pkg::MODE_DISC]);
                text.push_back(TXT_SPACE);
            end else begin
                if ((item.mode == lmf_pkg::MODE_LOWER_ALPH
                     || item.mode == lmf_pkg::MODE_UPPER_ALPH) && positive) begin
                    // bijective base 26
                    letter_base = upper ? TXT_UP_A : TXT_LOW_A;
                    v = raw;
                    while (v != 32'd0) begin
                        v = v - 32'd1;
                        text.push_front(letter_base + 8'(v % 32'd26));
                        v = v / 32'd26;
                    end
                end else if ((item.mode == lmf_pkg::MODE_LOWER_ROM
                              || item.mode == lmf_pkg::MODE_UPPER_ROM)
                             && positive && raw < ROMAN_CEIL) begin
                    v = raw;
                    for (int i = 0; i < 13; i++) begin
                        while (v >= step_value[i]) begin
                            for (int j = 0; j < step_text[i].len(); j++) begin
                                c = step_text[i][j];
                                text.push_back(upper ? c : c + 8'h20);
                            end
                            v = v - step_value[i];
                        end
                    end
                end else begin
                    // signed decimal fallback
                    v = raw[31] ? 32'd0 - raw : raw;
                    do begin
                        text.push_front(TXT_ZERO + 8'(v % 32'd10));
                        v = v / 32'd10;
                    end while (v != 32'd0);
                    if (raw[31])
                        text.push_front(TXT_MINUS);
                end
                text.push_back(TXT_DOT);
                text.push_back(TXT_SPACE);
            end
            if (text.size() > MARKER_MAX)
                text = text[0:MARKER_MAX-1];
            foreach (text[k])
                pending.push_back(lmf_pkg::out_t'{text_byte: text[k],
                                                  last_byte: k == text.size() - 1});
        endfunction

        task check_byte(lmf_pkg::out_t got);
            lmf_pkg::out_t want;
            bytes_seen++;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("byte %02h/last %0b with nothing expected",
                                          got.text_byte, got.last_byte));
                return;
            end
            want = pending.pop_front();
            if (got.text_byte !== want.text_byte)
                report_mismatch($sformatf("text_byte %02h, expected %02h (byte %0d)",
                                          got.text_byte, want.text_byte, bytes_seen));
            if (got.last_byte !== want.last_byte)
                report_mismatch($sformatf("last_byte %0b, expected %0b (byte %0d)",
                                          got.last_byte, want.last_byte, bytes_seen));
        endtask
    endclass

    logic          aclk;
    logic          aresetn;
    logic          s_valid;
    logic          s_ready;
    lmf_pkg::in_t  s_data;
    logic          m_valid;
    logic          m_ready;
    lmf_pkg::out_t m_data;

    marker_scoreboard sb = new();
    int items_accepted = 0;
    int cycle_count = 0;
    bit long_hold_done = 0;

    list_marker_formatter_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("ERROR: run exceeded %0d cycles", CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic lmf_pkg::in_t make_item(logic [3:0] mode, int number);
        lmf_pkg::in_t item;
        item.mode = mode;
        item.item_number = number;
        return item;
    endfunction

    function automatic lmf_pkg::in_t random_marker();
        int            corner_values[13];
        int            pick;
        lmf_pkg::in_t  item;
        corner_values = '{0, 1, -1, 3998, 3999, 4000, 26, 27, 702, 703, 18278,
                          32'h80000000, 32'h7fffffff};
        pick = $urandom_range(0, 99);
        if (pick < 4)
            item.mode = lmf_pkg::MODE_NONE;
        else if (pick < 20)
            item.mode = 4'($urandom_range(lmf_pkg::MODE_DISC, lmf_pkg::MODE_DISC_OPEN));
        else if (pick < 30)
            item.mode = 4'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
        else if (pick < 45)
            item.mode = MODE_DECIMAL;
        else if (pick < 65)
            item.mode = $urandom_range(0, 1) ? lmf_pkg::MODE_UPPER_ALPH
                                             : lmf_pkg::MODE_LOWER_ALPH;
        else
            item.mode = $urandom_range(0, 1) ? lmf_pkg::MODE_UPPER_ROM
                                             : lmf_pkg::MODE_LOWER_ROM;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            item.item_number = $urandom_range(1, 60);
        else if (pick < 55)
            item.item_number = $urandom_range(1, 3999);
        else if (pick < 65)
            item.item_number = corner_values[$urandom_range(0, 12)];
        else if (pick < 75)
            item.item_number = -int'($urandom_range(1, 5000));
        else
            item.item_number = $urandom;
        return item;
    endfunction

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_marker(lmf_pkg::in_t item);
        s_data <= item;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_marker(item);
        items_accepted++;
        @(negedge aclk);
    endtask

    initial begin : result_sink
        sink_pattern_t pattern;
        int stretch_left;
        int tick;
        int held;
        m_ready = 1'b0;
        pattern = SINK_OPEN;
        stretch_left = 0;
        tick = 0;
        forever begin
            @(negedge aclk);
            tick++;
            if (!long_hold_done && items_accepted >= HOLD_AFTER) begin
                // long back-pressure so the block fills and stalls its input
                long_hold_done = 1;
                m_ready <= 1'b0;
                for (held = 0; held < LONG_HOLD; held++)
                    @(negedge aclk);
            end else begin
                if (stretch_left == 0) begin
                    pattern = sink_pattern_t'($urandom_range(SINK_OPEN, SINK_EVERY_THIRD));
                    stretch_left = $urandom_range(10, 80);
                end
                stretch_left--;
                case (pattern)
                    SINK_OPEN:   m_ready <= 1'b1;
                    SINK_COIN:   m_ready <= ($urandom_range(0, 1) == 1);
                    SINK_MOSTLY: m_ready <= ($urandom_range(0, 4) != 0);
                    default:     m_ready <= (tick % 3 == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_byte(m_data);
    end

    initial begin : stimulus
        lmf_pkg::in_t directed[$];
        int  sent;
        int  burst;
        int  gap;
        int  styles_hit;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // glyphs, decimal extremes, letter and roman edges, none, unknown codes
        directed.push_back(make_item(lmf_pkg::MODE_DISC, 0));
        directed.push_back(make_item(MODE_CIRCLE, -1));
        directed.push_back(make_item(MODE_SQUARE, 32'h7fffffff));
        directed.push_back(make_item(MODE_DISC_CLOSED, 32'h80000000));
        directed.push_back(make_item(lmf_pkg::MODE_DISC_OPEN, 12345));
        directed.push_back(make_item(MODE_DECIMAL, 32'h80000000));
        directed.push_back(make_item(MODE_DECIMAL, 32'h7fffffff));
        directed.push_back(make_item(MODE_DECIMAL, 0));
        directed.push_back(make_item(lmf_pkg::MODE_LOWER_ALPH, 0));
        directed.push_back(make_item(lmf_pkg::MODE_LOWER_ALPH, -1));
        directed.push_back(make_item(lmf_pkg::MODE_LOWER_ALPH, 26));
        directed.push_back(make_item(lmf_pkg::MODE_UPPER_ALPH, 27));
        directed.push_back(make_item(lmf_pkg::MODE_UPPER_ALPH, 32'h7fffffff));
        directed.push_back(make_item(lmf_pkg::MODE_LOWER_ALPH, 1));
        directed.push_back(make_item(lmf_pkg::MODE_LOWER_ROM, 3888));
        directed.push_back(make_item(lmf_pkg::MODE_UPPER_ROM, 3999));
        directed.push_back(make_item(lmf_pkg::MODE_LOWER_ROM, 4000));
        directed.push_back(make_item(lmf_pkg::MODE_UPPER_ROM, 0));
        directed.push_back(make_item(lmf_pkg::MODE_LOWER_ROM, -4));
        directed.push_back(make_item(lmf_pkg::MODE_UPPER_ROM, 1994));
        directed.push_back(make_item(lmf_pkg::MODE_NONE, 7));
        directed.push_back(make_item(MODE_UNUSED_LO, -42));
        directed.push_back(make_item(MODE_UNUSED_LO + 4'd1, 0));
        directed.push_back(make_item(MODE_UNUSED_HI, 32'h7fffffff));
        directed.push_back(make_item(MODE_UNUSED_HI - 4'd2, 99));
        foreach (directed[i])
            send_marker(directed[i]);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
            for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
                send_marker(random_marker());
                sent++;
            end
            if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 8);
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.pending.size() != 0)
            sb.report_mismatch($sformatf("%0d expected bytes never arrived", sb.pending.size()));

        styles_hit = 0;
        foreach (sb.style_count[i])
            if (sb.style_count[i] != 0)
                styles_hit++;
        $display("%0d markers spelled over %0d of 16 style codes, %0d text bytes compared",
                 sb.markers, styles_hit, sb.bytes_seen);
        $display("receiver held off %0d cycles once, %0d mismatches", LONG_HOLD, sb.errors);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

@@ sim.f @@
src/lmf_pkg.sv
src/lmf_front.sv
src/lmf_queue.sv
src/lmf_back.sv
src/list_marker_formatter_top.sv
test/list_marker_formatter_top_tb.sv
